@@ hw/rtl/hst_pkg.sv @@
// types and constants shared by the height strip triangulator and its checker
`timescale 1ns / 1ps
`default_nettype none

package hst_pkg;

	localparam int COORD_W   = 32;
	localparam int X_SCALE_W = 18;
	localparam logic [X_SCALE_W-1:0] X_SCALE_RESET = 18'd21845;

	// configuration register indexes
	typedef logic [0:0] reg_index_t;
	localparam reg_index_t REG_VOID_CUTOFF = 1'b0;
	localparam reg_index_t REG_X_SCALE     = 1'b1;

	// one input word: a column of the strip
	typedef struct packed {
		logic signed [COORD_W-1:0] height_lower;
		logic signed [COORD_W-1:0] height_upper;
		logic signed [COORD_W-1:0] lower_y;
		logic signed [COORD_W-1:0] upper_y;
		logic                      first_column;
		logic                      last_column;
	} in_word_t;

	// one output word: a triangle
	typedef struct packed {
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] az;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
		logic signed [COORD_W-1:0] bz;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] cz;
		logic                      last_of_item;
	} out_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} vtx_t;

	// triangles of one column in emission order
	typedef enum logic [2:0] {
		TRI_LEFT0,
		TRI_LEFT1,
		TRI_CELL0,
		TRI_CELL1,
		TRI_RIGHT0,
		TRI_RIGHT1
	} tri_sel_t;

	localparam int NUM_TRI = 6;

endpackage

`default_nettype wire

@@ hw/rtl/height_strip_triangulator.sv @@
// height strip triangulator: columns of a two-row height strip in, triangles out
//
// usage: one word on the input channel is one column of the strip (two heights,
// the two row y values, first/last markers). each column gives 0 to 4 triangle
// words on the output channel, in order left wall, cell, right wall; the last
// triangle of a column has last_of_item set. a column with a void cell and no
// marker gives no word at all.
// the input word goes through the input register, the emit stage and the
// output register. throughput: one triangle per cycle while the receiver is
// ready, set by the single output register; a column's triangles leave one
// after another, an empty column gives none. the input register takes a new
// word while the emit stage still works on the previous one.
// reset clears the pipeline, the column count, the carried heights and the
// registers (void_cutoff 0, x_scale 21845). configuration writes take effect
// at once and are meant for when the block is drained.
// a stalled receiver holds the output word steady; the emit stage and then the
// input register fill and in_ready drops. nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module height_strip_triangulator #(
	parameter int MAX_COLUMNS = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire hst_pkg::reg_index_t cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire hst_pkg::in_word_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output hst_pkg::out_word_t      out_data
);
	import hst_pkg::*;

	localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int PW = CW + X_SCALE_W;
	localparam logic [CW:0] LAST_IDX = (CW+1)'(MAX_COLUMNS - 1);

	// configuration
	logic signed [COORD_W-1:0] void_cutoff_q;
	logic [X_SCALE_W-1:0]      x_scale_q;

	// column state
	logic signed [COORD_W-1:0] prev_lower_q;
	logic signed [COORD_W-1:0] prev_upper_q;
	logic [CW-1:0]             column_count_q;

	// stage 1: captured column
	logic                      valid_s1;
	in_word_t                  word_s1;
	logic [CW-1:0]             idx_s1;
	logic                      cell_s1;
	logic signed [COORD_W-1:0] pl_s1;
	logic signed [COORD_W-1:0] pu_s1;

	// stage 2: emit stage
	logic                      valid_s2;
	logic [NUM_TRI-1:0]        mask_s2;
	logic signed [COORD_W-1:0] x_s2;
	logic signed [COORD_W-1:0] xp_s2;
	logic signed [COORD_W-1:0] uy_s2;
	logic signed [COORD_W-1:0] ly_s2;
	logic signed [COORD_W-1:0] hu_s2;
	logic signed [COORD_W-1:0] hl_s2;
	logic signed [COORD_W-1:0] pl_s2;
	logic signed [COORD_W-1:0] pu_s2;
	logic                      adb_s2;

	// output register
	logic                      out_valid_q;
	out_word_t                 out_data_q;

	// accept side
	logic                      in_acc;
	logic [CW-1:0]             idx;
	logic                      cell_ok;
	logic [CW:0]               idx_inc;
	logic [CW-1:0]             count_next;

	// stage 1 to 2
	logic [PW-1:0]             prod_x;
	logic [PW-1:0]             prod_xp;
	logic signed [COORD_W:0]   diff_db;
	logic signed [COORD_W:0]   diff_ac;
	logic [COORD_W:0]          mag_db;
	logic [COORD_W:0]          mag_ac;
	logic [NUM_TRI-1:0]        mask_new;

	// emit side
	logic                      out_free;
	logic                      emit;
	logic                      s2_free;
	logic [NUM_TRI-1:0]        mask_rest;
	tri_sel_t                  sel;
	vtx_t                      v_u, v_l, v_ub, v_lb, v_c, v_d;
	vtx_t                      va, vb, vc;
	out_word_t                 tri_word;

	function automatic logic signed [COORD_W-1:0] sat_x(input logic [PW-1:0] p);
		logic over;
		over = |(p >> (COORD_W - 1));
		sat_x = over ? {1'b0, {(COORD_W-1){1'b1}}} : COORD_W'(p);
	endfunction

	function automatic vtx_t mk_vtx(
		input logic signed [COORD_W-1:0] x,
		input logic signed [COORD_W-1:0] y,
		input logic signed [COORD_W-1:0] z
	);
		vtx_t v;
		v.x = x;
		v.y = y;
		v.z = z;
		mk_vtx = v;
	endfunction

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			void_cutoff_q <= '0;
			x_scale_q     <= X_SCALE_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_VOID_CUTOFF: void_cutoff_q <= cfg_data;
				REG_X_SCALE:     x_scale_q     <= cfg_data[X_SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// accept side: column index, cell test, next count
	always_comb begin
		idx     = in_data.first_column ? '0 : column_count_q;
		cell_ok = (idx != '0)
			&& (in_data.height_upper > void_cutoff_q)
			&& (in_data.height_lower > void_cutoff_q)
			&& (prev_lower_q > void_cutoff_q)
			&& (prev_upper_q > void_cutoff_q);
		idx_inc = {1'b0, idx} + 1'b1;
		if (in_data.last_column)
			count_next = '0;
		else if (idx_inc > LAST_IDX)
			count_next = LAST_IDX[CW-1:0];
		else
			count_next = idx_inc[CW-1:0];
	end

	assign in_acc   = in_valid && in_ready;
	assign in_ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_lower_q   <= '0;
			prev_upper_q   <= '0;
			column_count_q <= '0;
		end else if (in_acc) begin
			prev_lower_q   <= in_data.height_lower;
			prev_upper_q   <= in_data.height_upper;
			column_count_q <= count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s2_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			word_s1 <= in_data;
			idx_s1  <= idx;
			cell_s1 <= cell_ok;
			pl_s1   <= prev_lower_q;
			pu_s1   <= prev_upper_q;
		end
	end

	// column x values and diagonal choice
	always_comb begin
		prod_x  = PW'(idx_s1) * PW'(x_scale_q);
		prod_xp = PW'(CW'(idx_s1 - 1'b1)) * PW'(x_scale_q);
		diff_db = {pu_s1[COORD_W-1], pu_s1} - {word_s1.height_lower[COORD_W-1],
			word_s1.height_lower};
		diff_ac = {word_s1.height_upper[COORD_W-1], word_s1.height_upper}
			- {pl_s1[COORD_W-1], pl_s1};
		mag_db  = diff_db[COORD_W] ? (COORD_W+1)'(-diff_db) : diff_db;
		mag_ac  = diff_ac[COORD_W] ? (COORD_W+1)'(-diff_ac) : diff_ac;
		mask_new = {word_s1.last_column, word_s1.last_column, cell_s1, cell_s1,
			idx_s1 == '0, idx_s1 == '0};
	end

	// emit stage control
	always_comb begin
		sel = TRI_RIGHT1;
		for (int i = NUM_TRI - 1; i >= 0; i--) begin
			if (mask_s2[i])
				sel = tri_sel_t'(3'(i));
		end
		mask_rest = mask_s2 & (mask_s2 - 1'b1);
		out_free  = !out_valid_q || out_ready;
		emit      = valid_s2 && (mask_s2 != '0) && out_free;
		s2_free   = !valid_s2 || (mask_s2 == '0) || (emit && (mask_rest == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			mask_s2  <= '0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
			mask_s2  <= mask_new;
		end else if (emit) begin
			mask_s2  <= mask_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			x_s2   <= sat_x(prod_x);
			xp_s2  <= sat_x(prod_xp);
			uy_s2  <= word_s1.upper_y;
			ly_s2  <= word_s1.lower_y;
			hu_s2  <= word_s1.height_upper;
			hl_s2  <= word_s1.height_lower;
			pl_s2  <= pl_s1;
			pu_s2  <= pu_s1;
			adb_s2 <= mag_db < mag_ac;
		end
	end

	// triangle assembly
	always_comb begin
		v_u  = mk_vtx(x_s2, uy_s2, hu_s2);
		v_l  = mk_vtx(x_s2, ly_s2, hl_s2);
		v_ub = mk_vtx(x_s2, uy_s2, '0);
		v_lb = mk_vtx(x_s2, ly_s2, '0);
		v_c  = mk_vtx(xp_s2, ly_s2, pl_s2);
		v_d  = mk_vtx(xp_s2, uy_s2, pu_s2);
		case (sel)
			TRI_LEFT0: begin
				va = v_u; vb = v_ub; vc = v_lb;
			end
			TRI_LEFT1: begin
				va = v_u; vb = v_lb; vc = v_l;
			end
			TRI_CELL0: begin
				va = v_u; vb = v_d; vc = adb_s2 ? v_l : v_c;
			end
			TRI_CELL1: begin
				if (adb_s2) begin
					va = v_c; vb = v_l; vc = v_d;
				end else begin
					va = v_u; vb = v_c; vc = v_l;
				end
			end
			TRI_RIGHT0: begin
				va = v_u; vb = v_lb; vc = v_ub;
			end
			TRI_RIGHT1: begin
				va = v_u; vb = v_l; vc = v_lb;
			end
			default: begin
				va = v_u; vb = v_l; vc = v_lb;
			end
		endcase
		tri_word.ax = va.x;
		tri_word.ay = va.y;
		tri_word.az = va.z;
		tri_word.bx = vb.x;
		tri_word.by = vb.y;
		tri_word.bz = vb.z;
		tri_word.cx = vc.x;
		tri_word.cy = vc.y;
		tri_word.cz = vc.z;
		tri_word.last_of_item = (mask_rest == '0);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= tri_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

@@ hw/rtl/hst_checker.sv @@
// port checker for the height strip triangulator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module hst_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire hst_pkg::in_word_t  in_data,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire hst_pkg::out_word_t out_data
);
	import hst_pkg::*;

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// triangles of one column leave back to back
	a_item_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last_of_item |=> out_valid)
		else $error("gap inside the triangles of one column");

	// empty and ready right after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> in_ready && !out_valid)
		else $error("block not empty after reset");

	// a waiting input word holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input word changed while waiting");

endmodule

bind height_strip_triangulator hst_checker u_hst_checker (.*);

`default_nettype wire
